// ----- hdl/case_insensitive_word_dictionary_macros.svh -----
// assertion macros for the word dictionary
`ifndef CASE_INSENSITIVE_WORD_DICTIONARY_MACROS_SVH
`define CASE_INSENSITIVE_WORD_DICTIONARY_MACROS_SVH

// same-cycle implication, checked outside reset
`define CID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/cid_pkg.sv -----
// shared types, constants and helpers of the word dictionary
`default_nettype none

package cid_pkg;

    localparam int BUCKETS_DEF  = 4096;
    localparam int MAX_WORD_DEF = 45;
    localparam int NODES_DEF    = 4096;

    localparam logic [63:0] HASH_SEED = 64'd5381;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_in;
        logic       last_char;
    } in_t;

    typedef struct packed {
        logic        found;
        logic [12:0] word_total;
        logic [1:0]  status;
    } out_t;

    typedef struct packed {
        logic       restart;
        logic       step;
        logic       start;
        logic [7:0] chr;
    } hash_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MODGO,
        S_MOD,
        S_HRD,
        S_HUSE,
        S_MRD,
        S_MCHK,
        S_CRD,
        S_CCHK,
        S_SWEEP,
        S_FIN
    } state_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]}) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/case_insensitive_word_dictionary.sv -----
// top level of the case-insensitive chained hash word dictionary
`default_nettype none

`include "case_insensitive_word_dictionary_macros.svh"

// Word dictionary: characters arrive one per transaction; insert and lookup
// words give one result after their last character, clear one after the
// sweep below. At the end of a word that is not too long and, for insert,
// finds a free node, the 64-bit djb2 hash is reduced modulo BUCKETS a byte
// at a time by reciprocal multiplication, a quotient estimate step and a
// correction step per byte, then the bucket head ram is read. Insert then
// finishes; lookup walks the chain, a read and a check state per node and
// per compared character, as the node rams have a registered read. After
// reset and after each clear all BUCKETS heads (4096 by default) are swept
// to null, one per cycle, with no input taken. The result sits in an output
// register, so characters of the next word are taken while it waits.
module case_insensitive_word_dictionary #(
    parameter int BUCKETS  = cid_pkg::BUCKETS_DEF,
    parameter int MAX_WORD = cid_pkg::MAX_WORD_DEF,
    parameter int NODES    = cid_pkg::NODES_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire cid_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output cid_pkg::out_t      m_data
);

    // widths derived from the sizing parameters
    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW    = $clog2(NODES + 1);
    localparam int NIW   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW    = $clog2(MAX_WORD + 1);
    localparam int AW    = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int CW    = (NW > 13) ? NW : 13;
    localparam int CHARS = (2 ** NIW) * (2 ** AW);
    localparam int MW    = LW + NW;

    localparam logic [NW-1:0] NIL = NW'(NODES);

    cid_pkg::state_t state_reg, state_next;

    logic [LW-1:0]  len_reg, len_next;
    logic           long_reg, long_next;
    logic [1:0]     op_reg, op_next;
    logic [NW-1:0]  count_reg, count_next;
    logic [NW-1:0]  cur_reg, cur_next;
    logic [NW-1:0]  nxt_reg, nxt_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [BW-1:0]  sweep_reg, sweep_next;
    logic           report_reg, report_next;
    logic           found_reg, found_next;
    logic [1:0]     status_reg, status_next;
    logic           m_valid_reg, m_valid_next;
    cid_pkg::out_t  m_data_reg, m_data_next;

    cid_pkg::hash_ctl_t hctl;
    logic               hdone;
    logic [BW-1:0]      bucket;

    // bucket heads ram
    logic           hd_we;
    logic [BW-1:0]  hd_waddr;
    logic [NW-1:0]  hd_wdata, hd_rdata;

    // node length and link ram
    logic           mt_we;
    logic [MW-1:0]  mt_wdata, mt_rdata;

    // node character ram and incoming word buffer
    logic           ch_we;
    logic [7:0]     ch_rdata, wb_rdata;
    logic           wb_we;

    logic           accept;
    logic           long_now;
    logic [CW-1:0]  total_wide;

    cid_hash #(.BUCKETS(BUCKETS)) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (hctl),
        .done    (hdone),
        .bucket  (bucket)
    );

    cid_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_heads (
        .aclk  (aclk),
        .we    (hd_we),
        .waddr (hd_waddr),
        .wdata (hd_wdata),
        .raddr (bucket),
        .rdata (hd_rdata)
    );

    cid_ram #(.WIDTH(MW), .DEPTH(NODES)) u_meta (
        .aclk  (aclk),
        .we    (mt_we),
        .waddr (count_reg[NIW-1:0]),
        .wdata (mt_wdata),
        .raddr (cur_reg[NIW-1:0]),
        .rdata (mt_rdata)
    );

    // characters go straight into the next free node as they arrive
    cid_ram #(.WIDTH(8), .DEPTH(CHARS)) u_chars (
        .aclk  (aclk),
        .we    (ch_we),
        .waddr ({count_reg[NIW-1:0], len_reg[AW-1:0]}),
        .wdata (s_data.char_in),
        .raddr ({cur_reg[NIW-1:0], idx_reg}),
        .rdata (ch_rdata)
    );

    cid_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_wbuf (
        .aclk  (aclk),
        .we    (wb_we),
        .waddr (len_reg[AW-1:0]),
        .wdata (s_data.char_in),
        .raddr (idx_reg),
        .rdata (wb_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cid_pkg::S_SWEEP;
            sweep_reg   <= '0;
            report_reg  <= 1'b0;
            count_reg   <= '0;
            len_reg     <= '0;
            long_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            report_reg  <= report_next;
            count_reg   <= count_next;
            len_reg     <= len_next;
            long_reg    <= long_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        cur_reg    <= cur_next;
        nxt_reg    <= nxt_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready    = (state_reg == cid_pkg::S_IDLE);
    assign accept     = s_valid && s_ready;
    assign long_now   = long_reg || (len_reg >= LW'(MAX_WORD));
    assign total_wide = CW'(count_reg);

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        long_next    = long_reg;
        op_next      = op_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        nxt_next     = nxt_reg;
        idx_next     = idx_reg;
        sweep_next   = sweep_reg;
        report_next  = report_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        hctl         = '0;
        hctl.chr     = s_data.char_in;
        hd_we        = 1'b0;
        hd_waddr     = bucket;
        hd_wdata     = count_reg;
        mt_we        = 1'b0;
        mt_wdata     = {len_reg, hd_rdata};
        ch_we        = 1'b0;
        wb_we        = 1'b0;

        case (state_reg)
            cid_pkg::S_IDLE: begin
                if (accept) begin
                    if (s_data.opcode == cid_pkg::OP_CLEAR) begin
                        // drop any partial word and empty the table
                        hctl.restart = 1'b1;
                        len_next     = '0;
                        long_next    = 1'b0;
                        count_next   = '0;
                        sweep_next   = '0;
                        report_next  = 1'b1;
                        found_next   = 1'b0;
                        status_next  = cid_pkg::ST_OK;
                        state_next   = cid_pkg::S_SWEEP;
                    end else if (s_data.opcode == cid_pkg::OP_INSERT ||
                                 s_data.opcode == cid_pkg::OP_LOOKUP) begin
                        hctl.step = 1'b1;
                        if (len_reg < LW'(MAX_WORD)) begin
                            wb_we    = 1'b1;
                            ch_we    = (count_reg != NIL);
                            len_next = len_reg + LW'(1);
                        end else begin
                            long_next = 1'b1;
                        end
                        if (s_data.last_char) begin
                            op_next     = s_data.opcode;
                            found_next  = 1'b0;
                            status_next = cid_pkg::ST_OK;
                            if (long_now) begin
                                status_next = cid_pkg::ST_LONG;
                                state_next  = cid_pkg::S_FIN;
                            end else if (s_data.opcode == cid_pkg::OP_INSERT &&
                                         count_reg == NIL) begin
                                status_next = cid_pkg::ST_FULL;
                                state_next  = cid_pkg::S_FIN;
                            end else begin
                                state_next = cid_pkg::S_MODGO;
                            end
                        end
                    end
                end
            end
            cid_pkg::S_MODGO: begin
                hctl.start = 1'b1;
                state_next = cid_pkg::S_MOD;
            end
            cid_pkg::S_MOD: begin
                if (hdone) begin
                    state_next = cid_pkg::S_HRD;
                end
            end
            cid_pkg::S_HRD: begin
                // head read address is the bucket itself
                state_next = cid_pkg::S_HUSE;
            end
            cid_pkg::S_HUSE: begin
                if (op_reg == cid_pkg::OP_INSERT) begin
                    // push new node at the chain head
                    mt_we      = 1'b1;
                    hd_we      = 1'b1;
                    count_next = count_reg + NW'(1);
                    state_next = cid_pkg::S_FIN;
                end else if (hd_rdata == NIL) begin
                    state_next = cid_pkg::S_FIN;
                end else begin
                    cur_next   = hd_rdata;
                    state_next = cid_pkg::S_MRD;
                end
            end
            cid_pkg::S_MRD: begin
                state_next = cid_pkg::S_MCHK;
            end
            cid_pkg::S_MCHK: begin
                nxt_next = mt_rdata[NW-1:0];
                idx_next = '0;
                if (mt_rdata[MW-1:NW] == len_reg) begin
                    state_next = cid_pkg::S_CRD;
                end else if (mt_rdata[NW-1:0] == NIL) begin
                    state_next = cid_pkg::S_FIN;
                end else begin
                    cur_next   = mt_rdata[NW-1:0];
                    state_next = cid_pkg::S_MRD;
                end
            end
            cid_pkg::S_CRD: begin
                state_next = cid_pkg::S_CCHK;
            end
            cid_pkg::S_CCHK: begin
                if (cid_pkg::fold_case(ch_rdata) != cid_pkg::fold_case(wb_rdata)) begin
                    // mismatch, move along the chain
                    if (nxt_reg == NIL) begin
                        state_next = cid_pkg::S_FIN;
                    end else begin
                        cur_next   = nxt_reg;
                        state_next = cid_pkg::S_MRD;
                    end
                end else if (LW'(idx_reg) + LW'(1) == len_reg) begin
                    found_next = 1'b1;
                    state_next = cid_pkg::S_FIN;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = cid_pkg::S_CRD;
                end
            end
            cid_pkg::S_SWEEP: begin
                hd_we    = 1'b1;
                hd_waddr = sweep_reg;
                hd_wdata = NIL;
                if (sweep_reg == BW'(BUCKETS - 1)) begin
                    state_next = report_reg ? cid_pkg::S_FIN : cid_pkg::S_IDLE;
                end else begin
                    sweep_next = sweep_reg + BW'(1);
                end
            end
            cid_pkg::S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.found      = found_reg;
                    m_data_next.word_total = total_wide[12:0];
                    m_data_next.status     = status_reg;
                    hctl.restart           = 1'b1;
                    len_next               = '0;
                    long_next              = 1'b0;
                    report_next            = 1'b0;
                    state_next             = cid_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = cid_pkg::S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // node pool never overflows
    `CID_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= NIL, "node count beyond pool")
    // a result appears only from the finish state
    `CID_ASSERT_NOW(a_result_src, $rose(m_valid_reg), $past(state_reg) == cid_pkg::S_FIN,
        "result without finish")
    // an insert that reaches the head update adds exactly one node
    `CID_ASSERT_NEXT(a_insert_count,
        state_reg == cid_pkg::S_HUSE && op_reg == cid_pkg::OP_INSERT,
        count_reg == $past(count_reg) + NW'(1), "insert did not advance count")
    // chain walk never dereferences null
    `CID_ASSERT_NOW(a_walk_nil, state_reg == cid_pkg::S_MRD, cur_reg != NIL,
        "chain walk on null node")

endmodule

`default_nettype wire

// ----- hdl/cid_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none

module cid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/cid_hash.sv -----
// djb2 accumulator and reduction modulo the bucket count
`default_nettype none

module cid_hash #(
    parameter int BUCKETS = cid_pkg::BUCKETS_DEF
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire cid_pkg::hash_ctl_t                         ctl,
    output logic                                            done,
    output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0]  bucket
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    // one step folds the running remainder with the next hash byte
    localparam int VW = BW + 8;
    // floor of 2**VW / BUCKETS, quotient estimate is short by at most one
    localparam logic [VW:0] RECIP = (VW+1)'((64'd1 << VW) / 64'(BUCKETS));

    logic [63:0]     hash_reg, hash_next;
    logic [BW-1:0]   rem_reg, rem_next;
    logic [VW-1:0]   quo_reg, quo_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic            phase_reg, phase_next;
    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [VW-1:0]   dividend;
    logic [2*VW-1:0] prod;
    logic [VW-1:0]   back;
    logic [VW-1:0]   diff;
    logic [BW:0]     trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg  <= cid_pkg::HASH_SEED;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            phase_reg <= 1'b0;
        end else begin
            hash_reg  <= hash_next;
            run_reg   <= run_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        hash_next  = hash_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        dividend   = {rem_reg, hash_reg[63:56]};
        prod       = {{VW{1'b0}}, dividend} * {{(VW-1){1'b0}}, RECIP};
        back       = quo_reg * VW'(BUCKETS);
        diff       = dividend - back;
        trial      = diff[BW:0];
        if (ctl.restart) begin
            hash_next = cid_pkg::HASH_SEED;
        end else if (ctl.step) begin
            hash_next = (hash_reg << 5) + hash_reg + {56'd0, cid_pkg::fold_case(ctl.chr)};
        end else if (ctl.start) begin
            run_next   = 1'b1;
            cnt_next   = '0;
            rem_next   = '0;
            phase_next = 1'b0;
        end else if (run_reg) begin
            // msb byte first, quotient estimate then correction
            if (!phase_reg) begin
                quo_next   = prod[2*VW-1:VW];
                phase_next = 1'b1;
            end else begin
                if (trial >= (BW+1)'(BUCKETS)) begin
                    rem_next = BW'(trial - (BW+1)'(BUCKETS));
                end else begin
                    rem_next = trial[BW-1:0];
                end
                hash_next  = hash_reg << 8;
                phase_next = 1'b0;
                cnt_next   = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    run_next  = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign bucket = rem_reg;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench of the case-insensitive word dictionary
`default_nettype none

module testbench;

    localparam int MAX_LEN     = cid_pkg::MAX_WORD_DEF;
    localparam int POOL_SIZE   = cid_pkg::NODES_DEF;
    localparam int TOTAL_ITEMS = 750;

    // opcode that the block ignores
    localparam logic [1:0] OP_NONE = 2'd3;

    // one directed row is one word, possibly left unterminated (or a single clear / ignored transaction)
    typedef struct {
        logic [1:0]     op_body;   // opcode on every byte but the last
        logic [1:0]     op;        // opcode on the last byte
        string          text;
        bit             term;      // mark the last byte as last_char
        bit             typed;     // expected result written out below
        cid_pkg::out_t  want;
    } word_row_t;

    typedef bit [6*8+MAX_LEN*8-1:0] word_key_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    cid_pkg::in_t  s_data = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    cid_pkg::out_t m_data;

    // dictionary shadow: folded words with their stored copies
    int        stored_copies[word_key_t];
    int        stored_total;
    byte       partial_bytes[MAX_LEN];
    int        partial_len;
    bit        partial_overflow;

    cid_pkg::out_t expected_results[$];
    int        mismatches;
    bit        no_gaps;
    int        words_sent;
    int        items_sent;
    string     vocab[$];
    word_row_t rows[$];

    case_insensitive_word_dictionary i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    // generous hard stop
    initial begin
        #20000000;
        $display("[case_insensitive_word_dictionary] ERROR");
        $finish;
    end

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // advance the shadow by one accepted transaction and queue what it yields
    task automatic dict_accept(input cid_pkg::in_t t, input bit typed,
                               input cid_pkg::out_t want);
        word_key_t     key;
        cid_pkg::out_t res;
        if (t.opcode == OP_NONE) begin
            return;
        end
        if (t.opcode == cid_pkg::OP_CLEAR) begin
            stored_copies.delete();
            stored_total = 0;
            partial_len = 0;
            partial_overflow = 1'b0;
            expected_results.push_back(typed ? want : cid_pkg::out_t'('0));
            return;
        end
        if (partial_len < MAX_LEN) begin
            partial_bytes[partial_len] = t.char_in;
            partial_len++;
        end else begin
            partial_overflow = 1'b1;
        end
        if (!t.last_char) begin
            return;
        end
        key = '0;
        key[MAX_LEN*8 +: 6] = partial_len[5:0];
        for (int i = 0; i < partial_len; i++) begin
            key[i*8 +: 8] = lower_byte(partial_bytes[i]);
        end
        res = '0;
        if (partial_overflow) begin
            res.status = cid_pkg::ST_LONG;
        end else if (t.opcode == cid_pkg::OP_INSERT) begin
            if (stored_total >= POOL_SIZE) begin
                res.status = cid_pkg::ST_FULL;
            end else begin
                stored_copies[key] = stored_copies.exists(key) ? stored_copies[key] + 1 : 1;
                stored_total++;
            end
        end else begin
            res.found = (stored_copies.exists(key) != 0);
        end
        res.word_total = stored_total[12:0];
        partial_len = 0;
        partial_overflow = 1'b0;
        expected_results.push_back(typed ? want : res);
    endtask

    // drive one transaction, hold it until taken, then update the shadow
    task automatic put_byte(input cid_pkg::in_t t, input bit typed,
                            input cid_pkg::out_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        dict_accept(t, typed, want);
    endtask

    task automatic send_word(input logic [1:0] op_body, input logic [1:0] op,
                             input byte bytes[$], input bit term,
                             input bit typed, input cid_pkg::out_t want);
        cid_pkg::in_t t;
        for (int i = 0; i < bytes.size(); i++) begin
            t.opcode    = (i == bytes.size() - 1) ? op : op_body;
            t.char_in   = bytes[i];
            t.last_char = (i == bytes.size() - 1) && term;
            put_byte(t, typed && t.last_char, want);
        end
    endtask

    task automatic send_clear(input bit typed);
        cid_pkg::in_t t;
        t.opcode    = cid_pkg::OP_CLEAR;
        t.char_in   = 8'($urandom_range(0, 255));
        t.last_char = 1'($urandom_range(0, 1));
        put_byte(t, typed, cid_pkg::out_t'('0));
    endtask

    function automatic void add_row(input logic [1:0] op_body, input logic [1:0] op,
                                    input string text, input bit term, input bit typed,
                                    input logic f, input int total, input logic [1:0] st);
        word_row_t r;
        r.op_body = op_body;
        r.op      = op;
        r.text    = text;
        r.term    = term;
        r.typed   = typed;
        r.want    = {f, total[12:0], st};
        rows.push_back(r);
    endfunction

    // copy of a word, in mixed case when flip is set
    function automatic void word_bytes(input string w, input bit flip, output byte q[$]);
        logic [7:0] c;
        q = {};
        for (int i = 0; i < w.len(); i++) begin
            c = w[i];
            if (flip && $urandom_range(0, 1) && c >= 8'h61 && c <= 8'h7A) begin
                c = c - 8'd32;
            end
            q.push_back(c);
        end
    endfunction

    // result side: random back-pressure, short and long stalls
    int stall_left = 0;
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 3) == 0) begin
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
            end
        end
    end

    // check every result transaction against the oldest expectation
    always @(posedge aclk) begin
        cid_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: found=%0d total=%0d status=%0d",
                             m_data.found, m_data.word_total, m_data.status);
                end
            end else begin
                want = expected_results.pop_front();
                if (m_data.found !== want.found || m_data.word_total !== want.word_total
                    || m_data.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: expected found=%0d total=%0d status=%0d,",
                                 want.found, want.word_total, want.status,
                                 " got found=%0d total=%0d status=%0d",
                                 m_data.found, m_data.word_total, m_data.status);
                    end
                end
            end
        end
    end

    initial begin
        byte          q[$];
        string        w;
        int           r;
        cid_pkg::in_t t;
        logic [1:0]   body;

        mismatches = 0;
        stored_total = 0;
        partial_len = 0;
        partial_overflow = 1'b0;
        no_gaps = 1'b0;
        items_sent = 0;

        // directed rows: lookups before any insert, case folding, duplicates,
        // letters' neighbors, length extremes, ignored opcode, clear mid-word,
        // mixed opcodes inside one word
        add_row(cid_pkg::OP_LOOKUP, cid_pkg::OP_LOOKUP, "hello", 1, 1, 0, 0, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_INSERT, cid_pkg::OP_INSERT, "Hello", 1, 1, 0, 1, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_LOOKUP, cid_pkg::OP_LOOKUP, "hELLo", 1, 1, 1, 1, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_INSERT, cid_pkg::OP_INSERT, "hello", 1, 1, 0, 2, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_LOOKUP, cid_pkg::OP_LOOKUP, "hell", 1, 1, 0, 2, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_LOOKUP, cid_pkg::OP_LOOKUP, "helloo", 1, 1, 0, 2, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_INSERT, cid_pkg::OP_INSERT, "@[`{", 1, 1, 0, 3, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_LOOKUP, cid_pkg::OP_LOOKUP, "@[`{", 1, 1, 1, 3, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_LOOKUP, cid_pkg::OP_LOOKUP, "`{@[", 1, 0, 0, 0, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_INSERT, cid_pkg::OP_INSERT, "Z", 1, 1, 0, 4, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_LOOKUP, cid_pkg::OP_LOOKUP, "z", 1, 1, 1, 4, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_INSERT, cid_pkg::OP_INSERT, {MAX_LEN{"A"}}, 1, 1, 0, 5,
                cid_pkg::ST_OK);
        add_row(cid_pkg::OP_LOOKUP, cid_pkg::OP_LOOKUP, {MAX_LEN{"a"}}, 1, 1, 1, 5,
                cid_pkg::ST_OK);
        add_row(cid_pkg::OP_INSERT, cid_pkg::OP_INSERT, {(MAX_LEN + 1){"a"}}, 1, 1, 0, 5,
                cid_pkg::ST_LONG);
        add_row(cid_pkg::OP_LOOKUP, cid_pkg::OP_LOOKUP, {(MAX_LEN + 1){"a"}}, 1, 1, 0, 5,
                cid_pkg::ST_LONG);
        add_row(cid_pkg::OP_INSERT, cid_pkg::OP_INSERT, "\377\200\177", 1, 0, 0, 0,
                cid_pkg::ST_OK);
        add_row(cid_pkg::OP_LOOKUP, cid_pkg::OP_LOOKUP, "\377\200\177", 1, 0, 0, 0,
                cid_pkg::ST_OK);
        add_row(OP_NONE, OP_NONE, "x", 1, 0, 0, 0, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_INSERT, cid_pkg::OP_INSERT, "abc", 0, 0, 0, 0, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_CLEAR, cid_pkg::OP_CLEAR, "", 0, 1, 0, 0, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_LOOKUP, cid_pkg::OP_LOOKUP, "abc", 1, 1, 0, 0, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_LOOKUP, cid_pkg::OP_INSERT, "Mix", 1, 1, 0, 1, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_INSERT, cid_pkg::OP_LOOKUP, "mIX", 1, 1, 1, 1, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_CLEAR, cid_pkg::OP_CLEAR, "", 1, 1, 0, 0, cid_pkg::ST_OK);
        add_row(cid_pkg::OP_INSERT, cid_pkg::OP_INSERT, {(MAX_LEN + 4){"t"}}, 1, 1, 0, 0,
                cid_pkg::ST_LONG);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].op == cid_pkg::OP_CLEAR) begin
                send_clear(1'b0);
                expected_results[$] = rows[i].want;
            end else begin
                word_bytes(rows[i].text, 1'b0, q);
                send_word(rows[i].op_body, rows[i].op, q, rows[i].term,
                          rows[i].typed, rows[i].want);
            end
        end
        send_clear(1'b1);

        // vocabulary of short words, mostly letters, for repeated hits
        for (int v = 0; v < 40; v++) begin
            w = "";
            r = $urandom_range(1, 8);
            for (int i = 0; i < r; i++) begin
                if ($urandom_range(0, 9) < 7) begin
                    w = {w, string'(byte'($urandom_range(8'h61, 8'h7A)))};
                end else begin
                    w = {w, string'(byte'($urandom_range(1, 255)))};
                end
            end
            vocab.push_back(w);
        end

        words_sent = 0;
        while (items_sent < TOTAL_ITEMS) begin
            // alternate stretches with and without idling
            no_gaps = ((words_sent / 16) % 4) == 3;
            r = $urandom_range(0, 99);
            if (r < 2) begin
                send_clear(1'b0);
            end else if (r < 6) begin
                // broken sequences: ignored opcode or a random-byte word
                if ($urandom_range(0, 1)) begin
                    t.opcode    = OP_NONE;
                    t.char_in   = 8'($urandom_range(0, 255));
                    t.last_char = 1'($urandom_range(0, 1));
                    put_byte(t, 1'b0, cid_pkg::out_t'('0));
                    continue;
                end
                q = {};
                repeat ($urandom_range(1, 6)) q.push_back(byte'($urandom_range(0, 255)));
                send_word(cid_pkg::OP_LOOKUP, 2'($urandom_range(0, 1)), q, 1, 0,
                          cid_pkg::out_t'('0));
            end else if (r < 10) begin
                q = {};
                repeat ($urandom_range(MAX_LEN - 1, MAX_LEN + 4))
                    q.push_back(byte'($urandom_range(0, 255)));
                send_word(2'($urandom_range(0, 1)), 2'($urandom_range(0, 1)), q, 1, 0,
                          cid_pkg::out_t'('0));
            end else begin
                word_bytes(vocab[$urandom_range(0, vocab.size() - 1)], 1'b1, q);
                body = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 1)) : 2'd0;
                if (r < 50) begin
                    send_word(body == 2'd0 ? cid_pkg::OP_INSERT : cid_pkg::OP_LOOKUP,
                              cid_pkg::OP_INSERT, q, 1, 0, cid_pkg::out_t'('0));
                end else begin
                    send_word(body == 2'd0 ? cid_pkg::OP_LOOKUP : cid_pkg::OP_INSERT,
                              cid_pkg::OP_LOOKUP, q, 1, 0, cid_pkg::out_t'('0));
                end
            end
            words_sent++;
        end
        s_valid <= 1'b0;

        // drain outstanding results, then let the block settle
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[case_insensitive_word_dictionary] OK");
        end else begin
            $display("[case_insensitive_word_dictionary] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hdl
hdl/cid_pkg.sv
hdl/cid_ram.sv
hdl/cid_hash.sv
hdl/case_insensitive_word_dictionary.sv
tb/testbench.sv
